// File: rtl/assert_macros.svh
// Assertion helpers shared by the timer queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/stq_pkg.sv
package stq_pkg;

	localparam int TIME_BITS     = 48;
	localparam int DELAY_BITS    = 32;
	localparam int OUT_ID_BITS   = 16;
	localparam int MAX_FIRE      = 16;
	localparam int FIRE_CNT_BITS = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		EV_FIRED     = 2'd0,
		EV_INSERTED  = 2'd1,
		EV_CANCELLED = 2'd2,
		EV_REJECTED  = 2'd3
	} ev_t;

	// What every cell does this cycle.
	typedef enum logic [1:0] {
		MODE_HOLD   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_POP    = 2'd3
	} mode_t;

	// Broadcast to the whole row; key is the new deadline on insert, now on pop.
	typedef struct packed {
		mode_t                  mode;
		logic [TIME_BITS-1:0]   key;
	} cell_cmd_t;

endpackage

// File: rtl/stq_cell.sv
`include "assert_macros.svh"

module stq_cell #(
	parameter int ID_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stq_pkg::cell_cmd_t            cmd,
	input  logic [ID_BITS-1:0]            cmd_id,
	input  logic                          left_valid,
	input  logic [stq_pkg::TIME_BITS-1:0] left_deadline,
	input  logic [ID_BITS-1:0]            left_id,
	input  logic                          left_gt,
	input  logic                          right_valid,
	input  logic [stq_pkg::TIME_BITS-1:0] right_deadline,
	input  logic [ID_BITS-1:0]            right_id,
	input  logic                          found_in,
	output logic                          found_out,
	output logic                          valid,
	output logic [stq_pkg::TIME_BITS-1:0] deadline,
	output logic [ID_BITS-1:0]            id,
	output logic                          gt,
	output logic                          due
);

	logic                          valid_q;
	logic [stq_pkg::TIME_BITS-1:0] deadline_q;
	logic [ID_BITS-1:0]            id_q;
	logic                          match;

	// Empty cells count as later than any deadline, so the boundary is monotonic.
	assign gt        = !valid_q || (deadline_q > cmd.key);
	assign due       = valid_q && (deadline_q <= cmd.key);
	assign match     = valid_q && (id_q == cmd_id);
	assign found_out = found_in || match;

	assign valid    = valid_q;
	assign deadline = deadline_q;
	assign id       = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.mode)
				stq_pkg::MODE_INSERT: begin
					if (gt) begin
						valid_q <= left_gt ? left_valid : 1'b1;
					end
				end
				stq_pkg::MODE_CANCEL: begin
					if (found_out) begin
						valid_q <= right_valid;
					end
				end
				stq_pkg::MODE_POP: valid_q <= right_valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.mode)
			stq_pkg::MODE_INSERT: begin
				if (gt && left_gt) begin
					deadline_q <= left_deadline;
					id_q       <= left_id;
				end else if (gt) begin
					deadline_q <= cmd.key;
					id_q       <= cmd_id;
				end
			end
			stq_pkg::MODE_CANCEL: begin
				if (found_out) begin
					deadline_q <= right_deadline;
					id_q       <= right_id;
				end
			end
			stq_pkg::MODE_POP: begin
				deadline_q <= right_deadline;
				id_q       <= right_id;
			end
			default: ;
		endcase
	end

	`ASSERT_IMPLIES(a_packed_front, clk, arst_n, right_valid, valid_q)
	`ASSERT_IMPLIES(a_sorted, clk, arst_n, valid_q && right_valid, deadline_q <= right_deadline)

endmodule

// File: rtl/sorted_timer_queue_top.sv
// Insert and cancel: taken in IDLE, carried out in EXEC; done rises as the FSM returns to IDLE.
// Tick: EXEC advances the clock, then POP gives one fired result per cycle off the head cell,
//   up to 16 per tick; a tick with nothing due gives no result. busy stays high from EXEC
//   until the FSM is back in IDLE, so a new request waits until the last one is finished.
// Results cannot be stalled: each is on the ports for one cycle, marked by done.
// Reset (arst_n low) empties every cell at once and zeroes the clock; no clearing pass.
`include "assert_macros.svh"

module sorted_timer_queue_top #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] timer_id,
	input  logic [31:0] delay_ms,
	output logic        done,
	output logic [1:0]  event_res,
	output logic [15:0] fired_id,
	output logic        last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_POP  = 3'b100
	} state_t;

	state_t                               state_q;
	logic [1:0]                           op_q;
	logic [ID_BITS-1:0]                   id_q;
	logic [stq_pkg::DELAY_BITS-1:0]       delay_q;
	logic [stq_pkg::TIME_BITS-1:0]        now_q;
	logic [stq_pkg::FIRE_CNT_BITS-1:0]    fire_cnt_q;
	logic                                 done_q;
	logic [1:0]                           event_res_q;
	logic [stq_pkg::OUT_ID_BITS-1:0]      fired_id_q;
	logic                                 last_q;

	stq_pkg::cell_cmd_t                   cmd;
	logic [stq_pkg::TIME_BITS-1:0]        new_deadline;
	logic                                 full;
	logic                                 found;
	logic                                 fire_last;

	logic [DEPTH-1:0]                     valid_w;
	logic [DEPTH-1:0]                     gt_w;
	logic [DEPTH-1:0]                     due_w;
	logic [DEPTH-1:0]                     found_w;
	logic [stq_pkg::TIME_BITS-1:0]        deadline_w [DEPTH];
	logic [ID_BITS-1:0]                   id_w [DEPTH];

	assign new_deadline = now_q + stq_pkg::TIME_BITS'(delay_q);
	assign full         = valid_w[DEPTH-1];
	assign found        = found_w[DEPTH-1];
	assign fire_last    = (fire_cnt_q == stq_pkg::FIRE_CNT_BITS'(stq_pkg::MAX_FIRE - 1))
		|| !due_w[1];

	always_comb begin
		cmd.mode = stq_pkg::MODE_HOLD;
		cmd.key  = new_deadline;
		unique case (state_q)
			ST_EXEC: begin
				if (op_q == stq_pkg::OP_INSERT && !full) begin
					cmd.mode = stq_pkg::MODE_INSERT;
				end else if (op_q == stq_pkg::OP_CANCEL) begin
					cmd.mode = stq_pkg::MODE_CANCEL;
				end
			end
			ST_POP: begin
				cmd.key = now_q;
				if (due_w[0]) begin
					cmd.mode = stq_pkg::MODE_POP;
				end
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                          l_valid;
		logic [stq_pkg::TIME_BITS-1:0] l_deadline;
		logic [ID_BITS-1:0]            l_id;
		logic                          l_gt;
		logic                          l_found;
		logic                          r_valid;
		logic [stq_pkg::TIME_BITS-1:0] r_deadline;
		logic [ID_BITS-1:0]            r_id;

		if (i == 0) begin : g_head
			assign l_valid    = 1'b0;
			assign l_deadline = '0;
			assign l_id       = '0;
			assign l_gt       = 1'b0;
			assign l_found    = 1'b0;
		end else begin : g_body
			assign l_valid    = valid_w[i-1];
			assign l_deadline = deadline_w[i-1];
			assign l_id       = id_w[i-1];
			assign l_gt       = gt_w[i-1];
			assign l_found    = found_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_valid    = 1'b0;
			assign r_deadline = '0;
			assign r_id       = '0;
		end else begin : g_inner
			assign r_valid    = valid_w[i+1];
			assign r_deadline = deadline_w[i+1];
			assign r_id       = id_w[i+1];
		end

		stq_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.cmd            (cmd),
			.cmd_id         (id_q),
			.left_valid     (l_valid),
			.left_deadline  (l_deadline),
			.left_id        (l_id),
			.left_gt        (l_gt),
			.right_valid    (r_valid),
			.right_deadline (r_deadline),
			.right_id       (r_id),
			.found_in       (l_found),
			.found_out      (found_w[i]),
			.valid          (valid_w[i]),
			.deadline       (deadline_w[i]),
			.id             (id_w[i]),
			.gt             (gt_w[i]),
			.due            (due_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			fire_cnt_q <= '0;
			done_q     <= 1'b0;
			op_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= op;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					unique case (op_q)
						stq_pkg::OP_INSERT, stq_pkg::OP_CANCEL: done_q <= 1'b1;
						stq_pkg::OP_TICK: begin
							now_q      <= now_q + 1'b1;
							fire_cnt_q <= '0;
							state_q    <= ST_POP;
						end
						default: ;
					endcase
				end
				ST_POP: begin
					if (due_w[0]) begin
						done_q     <= 1'b1;
						fire_cnt_q <= fire_cnt_q + 1'b1;
						if (fire_last) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload and result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			id_q    <= ID_BITS'(timer_id);
			delay_q <= delay_ms;
		end
		unique case (state_q)
			ST_EXEC: begin
				fired_id_q <= stq_pkg::OUT_ID_BITS'(id_q);
				last_q     <= 1'b1;
				if (op_q == stq_pkg::OP_INSERT) begin
					event_res_q <= full ? stq_pkg::EV_REJECTED : stq_pkg::EV_INSERTED;
				end else begin
					event_res_q <= found ? stq_pkg::EV_CANCELLED : stq_pkg::EV_REJECTED;
				end
			end
			ST_POP: begin
				fired_id_q  <= stq_pkg::OUT_ID_BITS'(id_w[0]);
				last_q      <= fire_last;
				event_res_q <= stq_pkg::EV_FIRED;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign event_res = event_res_q;
	assign fired_id  = fired_id_q;
	assign last      = last_q;

	`ASSERT_IMPLIES(a_last_ends_request, clk, arst_n, done_q, last_q == (state_q == ST_IDLE))
	`ASSERT_NEXT(a_exec_answers, clk, arst_n, state_q == ST_EXEC && op_q == stq_pkg::OP_INSERT, done_q && last_q)

endmodule
